// File: design/bsbq_pkg.sv
// Shared types and constants for the bracket substring balance query core.
package bsbq_pkg;

    localparam int DEF_MAX_LEN = 4096;
    localparam int ACT_W       = 2;
    localparam int SYM_W       = 3;
    localparam int POS_W       = 12;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 8;

    // Action codes carried in the low bits of the input transfer.
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_FINISH = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LTOP,
        S_LCHK,
        S_LFIN,
        S_BRD,
        S_BEV,
        S_BLK,
        S_QL,
        S_QR,
        S_QE
    } t_state;

    // Per-field write enables of the position memory.
    typedef struct packed {
        logic sym;
        logic cm;
        logic om;
        logic par;
        logic lab;
    } t_pm_wen;

endpackage

// File: design/bracket_substring_balance_query_core.sv
// Bracket matching, chain labeling and substring balance queries over one position memory.
//
//  Channel  | Dir | Payload (lowest bit first)
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | action[1:0], symbol[4:2], left_pos[16:5], right_pos[28:17]
//  m_axis   | out | balanced[0], answer_valid[1], overflowed[2]
//
// An opener load, a clear or a dropped load is done on acceptance; a closer
// load steps through stack read, opener read and, on a type match, two field writes.
// A finish sweeps the loaded string through the position memory, reading each
// position and labeling each matched opener and its partner. A query makes
// two reads of the single memory read port.
// Reset is synchronous and active low; memories are not cleared, the fill
// count marks which entries hold data. A result waits in the output register
// while the next transfer is accepted; a query only stalls if that register
// is still full when its own result is ready.
module bracket_substring_balance_query_core #(
    parameter int MAX_LEN = bsbq_pkg::DEF_MAX_LEN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // action[1:0], symbol[4:2], left_pos[16:5], right_pos[28:17], zero fill
    input  logic [bsbq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // balanced[0], answer_valid[1], overflowed[2], zero fill
    output logic [bsbq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bsbq_pkg::*;

    localparam int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW      = $clog2(MAX_LEN + 1);
    localparam int EW      = (CW > POS_W + 1) ? CW : POS_W + 1;
    localparam int OFS_CM  = SYM_W;
    localparam int OFS_OM  = SYM_W + 1;
    localparam int OFS_PAR = SYM_W + 2;
    localparam int OFS_LAB = SYM_W + 2 + AW;
    localparam int MW      = SYM_W + 2 + 2 * AW;

    // Input field unpacking.
    t_action           in_act;
    logic [SYM_W-1:0]  in_sym;
    logic [POS_W-1:0]  in_l;
    logic [POS_W-1:0]  in_r;
    logic              acc;

    assign in_act = t_action'(s_axis_tdata[1:0]);
    assign in_sym = s_axis_tdata[4:2];
    assign in_l   = s_axis_tdata[16:5];
    assign in_r   = s_axis_tdata[28:17];

    // Control and payload registers.
    t_state            r_state, n_state;
    logic [CW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_sc, n_sc;
    logic              r_built, n_built;
    logic              r_ovf, n_ovf;
    logic [SYM_W-1:0]  r_sym, n_sym;
    logic [AW-1:0]     r_pos, n_pos;
    logic [POS_W-1:0]  r_l, n_l;
    logic [POS_W-1:0]  r_r, n_r;
    logic [CW-1:0]     r_i, n_i;
    logic              r_prev_cm, n_prev_cm;
    logic [AW-1:0]     r_prev_lab, n_prev_lab;
    logic [AW-1:0]     r_lab, n_lab;
    logic [AW-1:0]     r_c, n_c;
    logic [MW-1:0]     r_wl, n_wl;
    logic              r_out_valid, n_out_valid;
    logic              r_out_bal, n_out_bal;
    logic              r_out_av, n_out_av;
    logic              r_out_ovf, n_out_ovf;

    // Memory ports.
    logic [MW-1:0]     r_pm [MAX_LEN];
    logic [MW-1:0]     r_pm_q;
    t_pm_wen           pm_wen;
    logic [AW-1:0]     pm_wa;
    logic [MW-1:0]     pm_wd;
    logic              pm_re;
    logic [AW-1:0]     pm_ra;
    logic [AW-1:0]     r_stk [MAX_LEN];
    logic [AW-1:0]     r_st_q;
    logic              st_we;
    logic [AW-1:0]     st_wa;
    logic [AW-1:0]     st_wd;
    logic              st_re;
    logic [AW-1:0]     st_ra;

    logic              last_pos;
    logic              q_valid;
    logic [AW-1:0]     lab_sel;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign last_pos      = ((r_i + CW'(1)) == r_len);
    assign q_valid       = r_built && (EW'(r_l) < EW'(r_len)) && (EW'(r_r) < EW'(r_len));
    assign lab_sel       = r_prev_cm ? r_prev_lab : AW'(r_i);

    // Position memory: symbol, match flags, partner and chain label per position.
    always_ff @(posedge i_clk) begin
        if (pm_wen.sym) r_pm[pm_wa][SYM_W-1:0]    <= pm_wd[SYM_W-1:0];
        if (pm_wen.cm)  r_pm[pm_wa][OFS_CM]       <= pm_wd[OFS_CM];
        if (pm_wen.om)  r_pm[pm_wa][OFS_OM]       <= pm_wd[OFS_OM];
        if (pm_wen.par) r_pm[pm_wa][OFS_PAR +: AW] <= pm_wd[OFS_PAR +: AW];
        if (pm_wen.lab) r_pm[pm_wa][OFS_LAB +: AW] <= pm_wd[OFS_LAB +: AW];
        if (pm_re)      r_pm_q                    <= r_pm[pm_ra];
    end

    // Stack memory of pending opener positions.
    always_ff @(posedge i_clk) begin
        if (st_we) r_stk[st_wa] <= st_wd;
        if (st_re) r_st_q       <= r_stk[st_ra];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (in_act)
                        ACT_LOAD: begin
                            if (!r_built && (r_len != CW'(MAX_LEN)) && in_sym[0]
                                && (r_sc != '0)) begin
                                n_state = S_LTOP;
                            end
                        end
                        ACT_FINISH: begin
                            if (!r_built && (r_len != '0)) n_state = S_BRD;
                        end
                        ACT_QUERY: n_state = S_QL;
                        ACT_CLEAR: n_state = S_IDLE;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LTOP: n_state = S_LCHK;
            S_LCHK: begin
                if ((r_pm_q[SYM_W-1:0] ^ SYM_W'(1)) == r_sym) n_state = S_LFIN;
                else                                        n_state = S_IDLE;
            end
            S_LFIN: n_state = S_IDLE;
            S_BRD:  n_state = S_BEV;
            S_BEV: begin
                if (r_pm_q[OFS_OM]) n_state = S_BLK;
                else if (last_pos)  n_state = S_IDLE;
                else                n_state = S_BRD;
            end
            S_BLK:  n_state = last_pos ? S_IDLE : S_BRD;
            S_QL:   n_state = S_QR;
            S_QR:   n_state = S_QE;
            S_QE: begin
                if (!r_out_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_len       = r_len;
        n_sc        = r_sc;
        n_built     = r_built;
        n_ovf       = r_ovf;
        n_sym       = r_sym;
        n_pos       = r_pos;
        n_l         = r_l;
        n_r         = r_r;
        n_i         = r_i;
        n_prev_cm   = r_prev_cm;
        n_prev_lab  = r_prev_lab;
        n_lab       = r_lab;
        n_c         = r_c;
        n_wl        = r_wl;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_bal   = r_out_bal;
        n_out_av    = r_out_av;
        n_out_ovf   = r_out_ovf;
        pm_wen      = '0;
        pm_wa       = '0;
        pm_wd       = '0;
        pm_re       = 1'b0;
        pm_ra       = '0;
        st_we       = 1'b0;
        st_wa       = '0;
        st_wd       = '0;
        st_re       = 1'b0;
        st_ra       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (in_act)
                        ACT_LOAD: begin
                            if (!r_built) begin
                                if (r_len == CW'(MAX_LEN)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_len  = r_len + CW'(1);
                                    n_pos  = AW'(r_len);
                                    n_sym  = in_sym;
                                    // New position starts unmatched.
                                    pm_wen.sym = 1'b1;
                                    pm_wen.cm  = 1'b1;
                                    pm_wen.om  = 1'b1;
                                    pm_wa      = AW'(r_len);
                                    pm_wd[SYM_W-1:0] = in_sym;
                                    if (!in_sym[0]) begin
                                        st_we = 1'b1;
                                        st_wa = AW'(r_sc);
                                        st_wd = AW'(r_len);
                                        n_sc  = r_sc + CW'(1);
                                    end else if (r_sc != '0) begin
                                        st_re = 1'b1;
                                        st_ra = AW'(r_sc - CW'(1));
                                    end
                                end
                            end
                        end
                        ACT_FINISH: begin
                            if (!r_built) begin
                                n_i       = '0;
                                n_prev_cm = 1'b0;
                                if (r_len == '0) n_built = 1'b1;
                            end
                        end
                        ACT_QUERY: begin
                            n_l = in_l;
                            n_r = in_r;
                        end
                        ACT_CLEAR: begin
                            n_len   = '0;
                            n_sc    = '0;
                            n_built = 1'b0;
                            n_ovf   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_LTOP: begin
                pm_re = 1'b1;
                pm_ra = r_st_q;
            end
            S_LCHK: begin
                if ((r_pm_q[SYM_W-1:0] ^ SYM_W'(1)) == r_sym) begin
                    // Matching type: mark the opener and pop it.
                    pm_wen.om = 1'b1;
                    pm_wen.par = 1'b1;
                    pm_wa = r_st_q;
                    pm_wd[OFS_OM] = 1'b1;
                    pm_wd[OFS_PAR +: AW] = r_pos;
                    n_sc = r_sc - CW'(1);
                end else begin
                    n_sc = '0;
                end
            end
            S_LFIN: begin
                pm_wen.cm = 1'b1;
                pm_wa = r_pos;
                pm_wd[OFS_CM] = 1'b1;
            end
            S_BRD: begin
                pm_re = 1'b1;
                pm_ra = AW'(r_i);
            end
            S_BEV: begin
                n_prev_cm  = r_pm_q[OFS_CM];
                n_prev_lab = r_pm_q[OFS_LAB +: AW];
                if (r_pm_q[OFS_OM]) begin
                    // A pair right after a matched closer continues that chain.
                    pm_wen.lab = 1'b1;
                    pm_wa = AW'(r_i);
                    pm_wd[OFS_LAB +: AW] = lab_sel;
                    n_lab = lab_sel;
                    n_c   = r_pm_q[OFS_PAR +: AW];
                end else if (last_pos) begin
                    n_built = 1'b1;
                end else begin
                    n_i = r_i + CW'(1);
                end
            end
            S_BLK: begin
                pm_wen.lab = 1'b1;
                pm_wa = r_c;
                pm_wd[OFS_LAB +: AW] = r_lab;
                if (last_pos) n_built = 1'b1;
                else          n_i = r_i + CW'(1);
            end
            S_QL: begin
                pm_re = 1'b1;
                pm_ra = AW'(r_l);
            end
            S_QR: begin
                n_wl  = r_pm_q;
                pm_re = 1'b1;
                pm_ra = AW'(r_r);
            end
            S_QE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_av    = q_valid;
                    n_out_ovf   = r_ovf;
                    n_out_bal   = q_valid && r_wl[OFS_OM] && r_pm_q[OFS_CM]
                                  && (r_wl[OFS_LAB +: AW] == r_pm_q[OFS_LAB +: AW]);
                end
            end
            default: ;
        endcase
    end

    // Register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_sc        <= '0;
            r_built     <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_sc        <= n_sc;
            r_built     <= n_built;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_sym      <= n_sym;
        r_pos      <= n_pos;
        r_l        <= n_l;
        r_r        <= n_r;
        r_i        <= n_i;
        r_prev_cm  <= n_prev_cm;
        r_prev_lab <= n_prev_lab;
        r_lab      <= n_lab;
        r_c        <= n_c;
        r_wl       <= n_wl;
        r_out_bal  <= n_out_bal;
        r_out_av   <= n_out_av;
        r_out_ovf  <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-3){1'b0}}, r_out_ovf, r_out_av, r_out_bal};

endmodule

// File: design/bsbq_checker.sv
// Port-level checks for the bracket substring balance query core, bound to the top level.
module bsbq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [bsbq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bsbq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bsbq_pkg::*;

    logic in_xfer;
    logic is_query;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign is_query = (s_axis_tdata[1:0] == ACT_QUERY);

    // A waiting result holds until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed before its transfer");

    // A balanced answer is always a valid answer.
    a_bal_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("balanced set on an invalid answer");

    // Only a query raises a result.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !is_query |=> !$rose(m_axis_tvalid))
        else $error("result appeared after a non-query transfer");

    // A query keeps the input side busy while memory is read.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && is_query |=> !s_axis_tready)
        else $error("input ready right after a query");

endmodule

bind bracket_substring_balance_query_core bsbq_checker u_bsbq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: sim/bracket_substring_balance_query_core_chk.sv
// Checker for the bracket substring balance query core: predicts and compares query answers.
module bracket_substring_balance_query_core_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    output int          o_fail_count,
    output int          o_answers_owed,
    output int          o_answers_seen,
    output int          o_balanced_seen,
    output int          o_invalid_seen
);
    import bsbq_pkg::*;

    localparam int DEPTH = DEF_MAX_LEN;

    typedef struct packed {
        logic balanced;
        logic answer_valid;
        logic overflowed;
    } t_answer;

    // Predicted copy of the string, the match stack and the union-find sets.
    logic [SYM_W-1:0] sym_mem [DEPTH];
    logic [POS_W-1:0] open_stack [DEPTH];
    logic [POS_W-1:0] mate_pos [DEPTH];
    bit               open_hit [DEPTH];
    bit               close_hit [DEPTH];
    int               uf_parent [DEPTH];
    int               uf_size [DEPTH];
    int               stack_depth;
    int               str_len;
    bit               sets_built;
    bit               load_dropped;
    t_answer          answers_owed [$];

    function automatic int root_pos(input int x);
        while (uf_parent[x] != x) x = uf_parent[x];
        return x;
    endfunction

    function automatic void merge_sets(input int a, input int b);
        int ra;
        int rb;
        int t;
        ra = root_pos(a);
        rb = root_pos(b);
        if (ra == rb) return;
        if (uf_size[ra] < uf_size[rb]) begin
            t = ra;
            ra = rb;
            rb = t;
        end
        uf_size[ra] += uf_size[rb];
        uf_parent[rb] = ra;
    endfunction

    function automatic void wipe_state();
        for (int i = 0; i < DEPTH; i++) begin
            open_hit[i] = 0;
            close_hit[i] = 0;
            uf_parent[i] = i;
            uf_size[i] = 1;
        end
        stack_depth = 0;
        str_len = 0;
        sets_built = 0;
        load_dropped = 0;
    endfunction

    function automatic void push_symbol(input logic [SYM_W-1:0] code);
        int pos;
        int top;
        if (sets_built) return;
        if (str_len >= DEPTH) begin
            load_dropped = 1;
            return;
        end
        pos = str_len;
        str_len++;
        sym_mem[pos] = code;
        if (!code[0]) begin
            open_stack[stack_depth] = pos;
            stack_depth++;
            return;
        end
        if (stack_depth == 0) return;
        top = open_stack[stack_depth-1];
        // A closer of the right type matches; any other type empties the stack.
        if ((sym_mem[top] ^ 3'd1) == code) begin
            mate_pos[top] = pos;
            open_hit[top] = 1;
            close_hit[pos] = 1;
            stack_depth--;
        end else begin
            stack_depth = 0;
        end
    endfunction

    function automatic void build_sets();
        int c;
        if (sets_built) return;
        for (int i = 0; i < str_len; i++) begin
            if (open_hit[i]) begin
                c = mate_pos[i];
                merge_sets(i, c);
                if (c + 1 < str_len && open_hit[c+1]) merge_sets(i, c + 1);
            end
        end
        sets_built = 1;
    endfunction

    function automatic t_answer answer_query(input int lpos, input int rpos);
        t_answer a;
        a.balanced = 0;
        a.answer_valid = 0;
        a.overflowed = load_dropped;
        if (sets_built && lpos < str_len && rpos < str_len) begin
            a.answer_valid = 1;
            a.balanced = open_hit[lpos] && close_hit[rpos] &&
                         root_pos(lpos) == root_pos(rpos);
        end
        return a;
    endfunction

    initial begin
        wipe_state();
        o_fail_count = 0;
        o_answers_seen = 0;
        o_balanced_seen = 0;
        o_invalid_seen = 0;
    end

    assign o_answers_owed = answers_owed.size();

    // Predict on every accepted input transfer.
    always @(posedge i_clk) begin
        t_action act;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            act = t_action'(i_s_tdata[1:0]);
            case (act)
                ACT_LOAD:   push_symbol(i_s_tdata[4:2]);
                ACT_FINISH: build_sets();
                ACT_CLEAR:  wipe_state();
                default: begin
                    answers_owed = {answers_owed,
                                    answer_query(i_s_tdata[16:5], i_s_tdata[28:17])};
                end
            endcase
        end
    end

    // Compare every accepted output transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            o_answers_seen++;
            if (answers_owed.size() == 0) begin
                $error("unexpected output transfer, tdata %h", i_m_tdata);
                o_fail_count++;
            end else begin
                want = answers_owed.pop_front();
                if (want.balanced) o_balanced_seen++;
                if (!want.answer_valid) o_invalid_seen++;
                if (i_m_tdata[0] !== want.balanced) begin
                    $error("balanced: expected %0b, got %0b", want.balanced, i_m_tdata[0]);
                    o_fail_count++;
                end
                if (i_m_tdata[1] !== want.answer_valid) begin
                    $error("answer_valid: expected %0b, got %0b",
                           want.answer_valid, i_m_tdata[1]);
                    o_fail_count++;
                end
                if (i_m_tdata[2] !== want.overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           want.overflowed, i_m_tdata[2]);
                    o_fail_count++;
                end
            end
        end
    end

endmodule

// File: sim/bracket_substring_balance_query_core_tb.sv
// Testbench top for the bracket substring balance query core: stimulus and verdict.
module bracket_substring_balance_query_core_tb;
    import bsbq_pkg::*;

    localparam int DEPTH = DEF_MAX_LEN;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    // action[1:0], symbol[4:2], left_pos[16:5], right_pos[28:17], zero fill
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    // balanced[0], answer_valid[1], overflowed[2], zero fill
    logic [7:0]  m_axis_tdata;

    int fail_count;
    int answers_owed;
    int answers_seen;
    int balanced_seen;
    int invalid_seen;

    // Idle pattern: 0 none, 1 sender idle, 2 receiver stalls, 3 both lightly.
    int idle_mode = 0;
    int items_sent = 0;
    int phase_count = 0;

    // Generator's own view of the string, used to aim queries at matched pairs.
    int str_len;
    int mate_of [DEPTH];
    int open_pos [$];
    int open_kind [$];

    always #5 i_clk = ~i_clk;

    bracket_substring_balance_query_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bracket_substring_balance_query_core_chk i_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_answers_owed  (answers_owed),
        .o_answers_seen  (answers_seen),
        .o_balanced_seen (balanced_seen),
        .o_invalid_seen  (invalid_seen)
    );

    // Receiver back-pressure follows the idle pattern.
    always @(posedge i_clk) begin
        case (idle_mode)
            2:       m_axis_tready <= ($urandom_range(0, 99) >= 71);
            3:       m_axis_tready <= ($urandom_range(0, 99) >= 14);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // One input transfer, with optional idle cycles ahead of it.
    task automatic send_item(input t_action act, input logic [2:0] sym,
                             input logic [11:0] lpos, input logic [11:0] rpos);
        int pct;
        pct = (idle_mode == 1) ? 71 : (idle_mode == 3) ? 14 : 0;
        if ($urandom_range(0, 99) < pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rpos, lpos, sym, act};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic clear_string();
        send_item(ACT_CLEAR, 3'($urandom), 12'($urandom), 12'($urandom));
        str_len = 0;
        open_pos.delete();
        open_kind.delete();
        for (int i = 0; i < DEPTH; i++) mate_of[i] = -1;
    endtask

    // Loads one symbol; mostly keeps the string well formed, sometimes injects noise.
    task automatic load_next(input int noise_pct);
        logic [2:0] code;
        int kind;
        if ($urandom_range(0, 99) < noise_pct) begin
            code = 3'($urandom);
            open_pos.delete();
            open_kind.delete();
        end else if (open_pos.size() == 0 || $urandom_range(0, 1) == 0) begin
            kind = $urandom_range(0, 3);
            code = 3'(kind * 2);
            if (str_len < DEPTH) begin
                open_pos = {open_pos, str_len};
                open_kind = {open_kind, kind};
            end
        end else begin
            kind = open_kind.pop_back();
            code = 3'(kind * 2 + 1);
            if (str_len < DEPTH) mate_of[open_pos.pop_back()] = str_len;
        end
        send_item(ACT_LOAD, code, 12'($urandom), 12'($urandom));
        if (str_len < DEPTH) str_len++;
    endtask

    // Queries aimed at chains of matched pairs, at random spots, or anywhere at all.
    task automatic query_some();
        int lpos;
        int rpos;
        int pick;
        pick = $urandom_range(0, 9);
        lpos = $urandom_range(0, DEPTH - 1);
        rpos = $urandom_range(0, DEPTH - 1);
        if (pick < 6 && str_len > 0) begin
            lpos = $urandom_range(0, str_len - 1);
            for (int t = 0; t < 8 && mate_of[lpos] < 0; t++)
                lpos = $urandom_range(0, str_len - 1);
            rpos = (mate_of[lpos] >= 0) ? mate_of[lpos] : $urandom_range(0, str_len - 1);
            while ($urandom_range(0, 1) == 1 && rpos + 1 < str_len && mate_of[rpos+1] >= 0)
                rpos = mate_of[rpos+1];
        end else if (pick < 8 && str_len > 0) begin
            lpos = $urandom_range(0, str_len - 1);
            rpos = $urandom_range(lpos, str_len - 1);
        end
        send_item(ACT_QUERY, 3'($urandom), 12'(lpos), 12'(rpos));
    endtask

    task automatic run_phase(input int n_loads, input int n_queries, input int noise_pct);
        clear_string();
        if ($urandom_range(0, 4) == 0) query_some();
        for (int i = 0; i < n_loads; i++) load_next(noise_pct);
        send_item(ACT_FINISH, 3'($urandom), 12'($urandom), 12'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            send_item(ACT_FINISH, 3'($urandom), 12'($urandom), 12'($urandom));
            send_item(ACT_LOAD, 3'($urandom), 12'($urandom), 12'($urandom));
        end
        for (int i = 0; i < n_queries; i++) query_some();
        phase_count++;
    endtask

    // Directed string: ) ( ) [ } { } < > (  covers empty-stack and wrong-type closers.
    task automatic directed_part();
        logic [2:0] codes [10];
        codes = '{3'd1, 3'd0, 3'd1, 3'd2, 3'd5, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0};
        clear_string();
        send_item(ACT_QUERY, 3'd0, 12'd0, 12'd0);
        foreach (codes[i]) send_item(ACT_LOAD, codes[i], 12'd0, 12'd0);
        send_item(ACT_FINISH, 3'd0, 12'd0, 12'd0);
        send_item(ACT_FINISH, 3'd0, 12'd0, 12'd0);
        send_item(ACT_LOAD, 3'd3, 12'd0, 12'd0);
        send_item(ACT_QUERY, 3'd7, 12'd5, 12'd8);
        send_item(ACT_QUERY, 3'd0, 12'd1, 12'd2);
        send_item(ACT_QUERY, 3'd0, 12'd3, 12'd4);
        send_item(ACT_QUERY, 3'd0, 12'd9, 12'd9);
        send_item(ACT_QUERY, 3'd0, 12'd4095, 12'd4095);
        send_item(ACT_QUERY, 3'd0, 12'd0, 12'd10);
    endtask

    initial begin
        int n;
        for (int i = 0; i < DEPTH; i++) mate_of[i] = -1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_part();

        // Hold the sender off until every answer has come back.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (answers_owed != 0) @(posedge i_clk);

        // Random phases under the four idle patterns.
        while (items_sent < 1550) begin
            idle_mode = phase_count % 5 == 4 ? 0 : phase_count % 4;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                            : $urandom_range(1, 40);
            run_phase(n, n / 2 + 6, $urandom_range(0, 1) ? 0 : 8);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (answers_owed != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Ran %0d input transfers over %0d strings under four idle patterns.",
                 items_sent, phase_count + 1);
        $display("Checked %0d answers: %0d balanced, %0d invalid.",
                 answers_seen, balanced_seen, invalid_seen);
        if (fail_count == 0 && answers_owed == 0)
            $display("bracket_substring_balance_query_core_tb: PASS");
        else
            $display("bracket_substring_balance_query_core_tb: FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20000000;
        $display("bracket_substring_balance_query_core_tb: FAIL");
        $finish;
    end

endmodule
